### design/rsfp_pkg.sv
package rsfp_pkg;

   localparam int unsigned StoreDepth = 20;
   localparam int unsigned CountWidth = $clog2(StoreDepth + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(StoreDepth);

   localparam logic [7:0] ByteTail    = 8'h55;
   localparam logic [7:0] ByteFoot0   = 8'h04;
   localparam logic [7:0] ByteFoot1   = 8'h03;
   localparam logic [7:0] ByteFoot2   = 8'h02;
   localparam logic [7:0] ByteFoot3   = 8'h01;
   localparam logic [7:0] ByteSync    = 8'hAA;
   localparam logic [7:0] TypeNone    = 8'h00;
   localparam logic [7:0] TypeMotion  = 8'h01;
   localparam logic [7:0] TypeStill   = 8'h02;
   localparam logic [7:0] CfgHead0    = 8'hFD;
   localparam logic [7:0] CfgHead1    = 8'hFC;
   localparam logic [7:0] CfgHead2    = 8'hFB;
   localparam logic [7:0] CfgHead3    = 8'hFA;
   localparam logic [7:0] CfgCmd      = 8'h73;
   localparam logic [7:0] CfgAck      = 8'h01;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_MOTION = 2'd1,
      KIND_STILL  = 2'd2,
      KIND_CONFIG = 2'd3
   } kind_type;

   typedef logic [7:0] hdr_type [StoreDepth];

   typedef struct packed {
      kind_type    frame_kind;
      logic        presence;
      logic        motion;
      logic [15:0] distance;
      logic [15:0] max_motion_range;
      logic [15:0] min_motion_range;
      logic [15:0] max_presence_range;
      logic [15:0] min_presence_range;
      logic [15:0] unoccupied_time;
   } result_type;

endpackage

### design/radar_sensor_frame_parser.sv
// Radar sensor frame parser.
// Request channel (req_*): one received serial byte per request in req_tdata.
// Result channel (rsp_*): one decoded frame per result; frame kind in rsp_tuser,
// flags, distance and configuration values packed in rsp_tdata.
// A frame closes on the byte that completes 55 55 or 04 03 02 01 within the
// frame. Its result, if the frame is recognized, is registered in the output
// slot, or in the skid slot while the receiver stalls; other bytes give no result.
// Throughput: one byte per cycle while req_tready is high. Header bytes live
// in a 20-entry register file; end detection and decode are one level of
// compare logic ahead of the result register.
// Reset clears the byte counter, the recent-byte history and the valid flags
// of both result slots; stored header bytes are not cleared.
// When the receiver stalls, one further result is held in a skid slot; only
// while that slot is full does req_tready drop.
module radar_sensor_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [0] presence, [1] motion, [17:2] distance,
                                     // [33:18] max_motion_range, [49:34] min_motion_range,
                                     // [65:50] max_presence_range,
                                     // [81:66] min_presence_range,
                                     // [97:82] unoccupied_time, [103:98] zero
   output logic [1:0]   rsp_tuser    // [1:0] frame_kind
);

   localparam int unsigned CW = rsfp_pkg::CountWidth;

   logic [7:0]          hdr_ff [rsfp_pkg::StoreDepth];
   rsfp_pkg::hdr_type   hdr_view;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       frame_len;
   logic [7:0]          recent_ff [3];
   logic [7:0]          recent_in [3];
   logic                req_accept;
   logic                frame_end;
   logic                hit;
   rsfp_pkg::result_type result;
   logic                new_valid;

   rsfp_pkg::result_type out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;
   rsfp_pkg::result_type skid_ff, skid_in;
   logic                 skid_valid_ff, skid_valid_in;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   assign frame_len = (count_ff == rsfp_pkg::CountMax) ? rsfp_pkg::CountMax
                                                       : count_ff + CW'(1);

   assign frame_end = ((count_ff >= CW'(1)) && recent_ff[0] == rsfp_pkg::ByteTail
                       && req_tdata == rsfp_pkg::ByteTail)
                   || ((count_ff >= CW'(3)) && recent_ff[2] == rsfp_pkg::ByteFoot0
                       && recent_ff[1] == rsfp_pkg::ByteFoot1
                       && recent_ff[0] == rsfp_pkg::ByteFoot2
                       && req_tdata == rsfp_pkg::ByteFoot3);

   // header as it stands with the incoming byte included
   always_comb begin
      for (int i = 0; i < rsfp_pkg::StoreDepth; i++) begin
         hdr_view[i] = (count_ff == CW'(i)) ? req_tdata : hdr_ff[i];
      end
   end

   rsfp_classify u_classify (
      .hdr       (hdr_view),
      .frame_len (frame_len),
      .hit       (hit),
      .result    (result)
   );

   assign new_valid = req_accept && frame_end && hit;

   always_comb begin
      count_in  = count_ff;
      recent_in = recent_ff;
      if (req_accept) begin
         if (frame_end) begin
            count_in  = '0;
            recent_in = '{default: 8'h00};
         end else begin
            count_in     = frame_len;
            recent_in[2] = recent_ff[1];
            recent_in[1] = recent_ff[0];
            recent_in[0] = req_tdata;
         end
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_in       = result;
         out_valid_in = new_valid;
      end else begin
         if (new_valid) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         recent_ff     <= '{default: 8'h00};
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         recent_ff     <= recent_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (req_accept && count_ff < rsfp_pkg::CountMax) begin
         hdr_ff[count_ff] <= req_tdata;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.frame_kind;
   assign rsp_tdata  = {6'd0,
                        out_ff.unoccupied_time,
                        out_ff.min_presence_range,
                        out_ff.max_presence_range,
                        out_ff.min_motion_range,
                        out_ff.max_motion_range,
                        out_ff.distance,
                        out_ff.motion,
                        out_ff.presence};

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full while output slot empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rsfp_pkg::CountMax)
      else $error("byte count beyond store depth");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && frame_end) |=> (count_ff == '0 && recent_ff[0] == 8'h00))
      else $error("frame state not cleared after frame end");

   a_config_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == rsfp_pkg::KIND_CONFIG) |-> (rsp_tdata[1:0] == 2'b00))
      else $error("configuration reply carries presence or motion");
`endif

endmodule

### design/rsfp_classify.sv
module rsfp_classify (
   input  rsfp_pkg::hdr_type                     hdr,
   input  logic [rsfp_pkg::CountWidth-1:0]       frame_len,
   output logic                                  hit,
   output rsfp_pkg::result_type                  result
);

   logic is_sync;
   logic is_cfg;
   logic len_ge3;
   logic len_ge5;

   assign is_sync = (hdr[0] == rsfp_pkg::ByteSync) && (hdr[1] == rsfp_pkg::ByteSync);
   assign is_cfg  = (frame_len == rsfp_pkg::CountMax)
                    && (hdr[0] == rsfp_pkg::CfgHead0) && (hdr[1] == rsfp_pkg::CfgHead1)
                    && (hdr[2] == rsfp_pkg::CfgHead2) && (hdr[3] == rsfp_pkg::CfgHead3)
                    && (hdr[6] == rsfp_pkg::CfgCmd) && (hdr[7] == rsfp_pkg::CfgAck);
   assign len_ge3 = frame_len >= rsfp_pkg::CountWidth'(3);
   assign len_ge5 = frame_len >= rsfp_pkg::CountWidth'(5);

   always_comb begin
      hit    = 1'b0;
      result = '0;
      result.frame_kind = rsfp_pkg::KIND_NONE;
      if (len_ge3) begin
         priority if (is_sync && hdr[2] == rsfp_pkg::TypeNone) begin
            hit = 1'b1;
         end else if (is_sync && (hdr[2] == rsfp_pkg::TypeMotion
                                  || hdr[2] == rsfp_pkg::TypeStill)) begin
            hit               = len_ge5;
            result.frame_kind = (hdr[2] == rsfp_pkg::TypeMotion) ? rsfp_pkg::KIND_MOTION
                                                                 : rsfp_pkg::KIND_STILL;
            result.presence   = 1'b1;
            result.motion     = (hdr[2] == rsfp_pkg::TypeMotion);
            result.distance   = {hdr[4], hdr[3]};
         end else if (is_cfg) begin
            hit                       = 1'b1;
            result.frame_kind         = rsfp_pkg::KIND_CONFIG;
            result.max_motion_range   = {hdr[11], hdr[10]};
            result.min_motion_range   = {hdr[13], hdr[12]};
            result.max_presence_range = {hdr[15], hdr[14]};
            result.min_presence_range = {hdr[17], hdr[16]};
            result.unoccupied_time    = {hdr[19], hdr[18]};
         end else begin
            hit = 1'b0;
         end
      end
   end

endmodule
